>>> src/itda_pkg.sv
// shared types and constants for the integer to decimal text converter
// no dependencies
package itda_pkg;

   localparam int WORD_W      = 32;
   localparam int DIGIT_COUNT = 10;
   localparam int BCD_W       = 4 * DIGIT_COUNT;
   localparam int IDX_W       = $clog2(DIGIT_COUNT);
   localparam int STEP_W      = $clog2(WORD_W);
   localparam int CHAR_W      = 6;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

   // largest leading digit of a 32-bit magnitude (4294967295)
   localparam logic [3:0] TOP_DIGIT_MAX = 4'd4;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // command codes of the request beat
   localparam logic CMD_SIGNED   = 1'b0;
   localparam logic CMD_UNSIGNED = 1'b1;

   // classified job handed from the front to the back
   typedef struct packed {
      logic [WORD_W-1:0] mag;
      logic              negative;
   } job_type;

endpackage

>>> src/itda_if.sv
// request and response channel interfaces
// depends on itda_pkg
interface itda_req_if;
   logic                        valid;
   logic                        ready;
   logic [itda_pkg::WORD_W-1:0] value;
   logic                        cmd;

   modport source (output valid, output value, output cmd, input ready);
   modport sink   (input valid, input value, input cmd, output ready);
endinterface

interface itda_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [itda_pkg::CHAR_W-1:0] char_code;
   logic                        last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

>>> src/itda_front.sv
// front stage: takes request beats, works out sign and magnitude
// depends on itda_pkg and itda_req_if
module itda_front (
   input  logic                 clock,
   input  logic                 reset,
   itda_req_if.sink             req_bus,
   output logic                 push_valid,
   output itda_pkg::job_type    push_job,
   input  logic                 push_ready
);

   logic              valid_ff, valid_in;
   itda_pkg::job_type job_ff, job_in;
   logic              negative;
   logic              take;

   // classify the incoming word
   assign negative = (req_bus.cmd == itda_pkg::CMD_SIGNED) && req_bus.value[itda_pkg::WORD_W-1];
   assign req_bus.ready = !valid_ff || push_ready;
   assign take = req_bus.valid && req_bus.ready;

   always_comb begin
      job_in.negative = negative;
      job_in.mag      = negative ? (~req_bus.value + itda_pkg::WORD_W'(1)) : req_bus.value;
   end

   // holding register towards the queue
   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_job   = job_ff;

endmodule

>>> src/itda_queue.sv
// short job queue between front and back
// depends on itda_pkg
module itda_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  itda_pkg::job_type    push_job,
   output logic                 push_ready,
   output logic                 pop_valid,
   output itda_pkg::job_type    pop_job,
   input  logic                 pop_ready
);

   itda_pkg::job_type                 slot_ff [itda_pkg::QUEUE_DEPTH];
   logic [itda_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [itda_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [itda_pkg::QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                              push, pop;

   assign push_ready = (count_ff != itda_pkg::QUEUE_CNT_W'(itda_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == itda_pkg::QUEUE_PTR_W'(itda_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + itda_pkg::QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == itda_pkg::QUEUE_PTR_W'(itda_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + itda_pkg::QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + itda_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - itda_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= itda_pkg::QUEUE_CNT_W'(itda_pkg::QUEUE_DEPTH))
      else $error("queue fill beyond depth");
`endif

endmodule

>>> src/itda_back.sv
// back stage: double-dabble conversion and character emission
// depends on itda_pkg and itda_rsp_if
module itda_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   input  itda_pkg::job_type    pop_job,
   output logic                 pop_ready,
   itda_rsp_if.source           rsp_bus
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [itda_pkg::WORD_W-1:0]        bin_ff, bin_in;
   logic [itda_pkg::BCD_W-1:0]         bcd_ff, bcd_in;
   logic [itda_pkg::BCD_W-1:0]         bcd_adj;
   logic [itda_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [itda_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic [itda_pkg::IDX_W-1:0]         lead_idx;
   logic                               sign_ff, sign_in;
   logic                               out_valid_ff, out_valid_in;
   logic [itda_pkg::CHAR_W-1:0]        out_char_ff, out_char_in;
   logic                               out_last_ff, out_last_in;
   logic                               out_free, emit;
   logic                               pop;
   logic [3:0]                         digit;

   assign pop_ready = (state_ff == ST_IDLE);
   assign pop       = pop_valid && pop_ready;
   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign emit      = (state_ff == ST_EMIT) && out_free;
   assign digit     = bcd_ff[idx_ff*4 +: 4];

   // add three to every bcd digit of five or more
   always_comb begin
      for (int i = 0; i < itda_pkg::DIGIT_COUNT; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ?
                             bcd_ff[i*4 +: 4] + 4'd3 : bcd_ff[i*4 +: 4];
      end
   end

   // highest non-zero digit, or the units digit for zero
   always_comb begin
      lead_idx = '0;
      for (int i = 1; i < itda_pkg::DIGIT_COUNT; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            lead_idx = itda_pkg::IDX_W'(i);
         end
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      sign_in  = sign_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               bin_in   = pop_job.mag;
               sign_in  = pop_job.negative;
               bcd_in   = '0;
               step_in  = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            {bcd_in, bin_in} = {bcd_adj[itda_pkg::BCD_W-2:0], bin_ff, 1'b0};
            step_in = step_ff + itda_pkg::STEP_W'(1);
            if (step_ff == itda_pkg::STEP_W'(itda_pkg::WORD_W - 1)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in   = lead_idx;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit) begin
               if (sign_ff) begin
                  sign_in = 1'b0;
               end else if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - itda_pkg::IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (emit) begin
         out_valid_in = 1'b1;
         if (sign_ff) begin
            out_char_in = itda_pkg::CHAR_MINUS;
            out_last_in = 1'b0;
         end else begin
            out_char_in = itda_pkg::CHAR_ZERO + {2'b00, digit};
            out_last_in = (idx_ff == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      sign_ff     <= sign_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.char_code = out_char_ff;
   assign rsp_bus.last      = out_last_ff;

`ifndef NO_ASSERTIONS
   a_pop_starts_conv: assert property (@(posedge clock) disable iff (reset)
      pop |=> (state_ff == ST_CONV) && (step_ff == '0))
      else $error("job taken without a fresh conversion");
   a_conv_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) && (step_ff == itda_pkg::STEP_W'(itda_pkg::WORD_W - 1))
      |=> state_ff == ST_SCAN)
      else $error("conversion did not end after the last shift");
   a_top_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (bcd_ff[itda_pkg::BCD_W-1 -: 4] <= itda_pkg::TOP_DIGIT_MAX))
      else $error("leading bcd digit out of range");
`endif

endmodule

>>> src/int_to_decimal_ascii.sv
// top level of the integer to decimal text converter
// depends on itda_pkg, itda_if, itda_front, itda_queue and itda_back
//
//  channel   role     beat payload
//  req_bus   sink     value (32 bits), cmd (0 signed, 1 unsigned)
//  rsp_bus   source   char_code (6 bits ascii), last (final character)
//
// the back loads a number, shifts it once per bit in the shared shift register,
// finds the leading digit and then emits one character (1 to 11) per cycle while
// the response does not stall; it takes no new number until the last character is
// out. a request passes the front register, the queue and the output register.
// reset is synchronous and clears the valid flags, queue count and back state.
// a two-entry queue lets the front keep taking beats while the back is busy;
// a response stall holds character emission in the back.
module int_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   itda_req_if.sink    req_bus,
   itda_rsp_if.source  rsp_bus
);

   logic              push_valid, push_ready;
   logic              pop_valid, pop_ready;
   itda_pkg::job_type push_job, pop_job;

   itda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   itda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   itda_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
